[rtl/itpc_pkg.sv]
// Package for the IPv4 tunnel packet checker: beat payload types,
// verdict codes, register indexes and size constants.
// No dependencies.
package itpc_pkg;

   // Register indexes of the configuration port
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ASSIGNMENT_PRESENT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PACKET_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOST_ADDRESS       = 2'd2;

   // Size and header constants
   localparam int unsigned COUNT_WIDTH = 17;
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT     = 17'h10000;
   localparam logic [COUNT_WIDTH-1:0] MIN_PACKET_LEN  = 17'd20;
   localparam logic [15:0]            MTU_RESET       = 16'd1500;
   localparam logic [3:0]             IPV4_VERSION    = 4'd4;
   localparam logic [5:0]             MIN_HEADER_LEN  = 6'd20;
   localparam logic [3:0]             NIBBLE_MASK     = 4'hF;

   // Byte offsets of the address words, in 4-byte word units
   localparam logic [14:0] SRC_ADDR_WORD = 15'd3;
   localparam logic [14:0] DST_ADDR_WORD = 15'd4;

   // Byte offsets of the version byte and the total-length field
   localparam logic [COUNT_WIDTH-1:0] POS_VERSION   = 17'd0;
   localparam logic [COUNT_WIDTH-1:0] POS_TOTAL_HI  = 17'd2;
   localparam logic [COUNT_WIDTH-1:0] POS_TOTAL_LO  = 17'd3;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT   = 2'd0,
      VERDICT_SIZE     = 2'd1,
      VERDICT_HEADER   = 2'd2,
      VERDICT_ADDRESS  = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       check_dst;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]             verdict;
      logic [COUNT_WIDTH-1:0] packet_length;
   } rsp_payload_type;

endpackage

[rtl/itpc_stream_if.sv]
// Valid/ready stream channel for the IPv4 tunnel packet checker.
// The payload type is set where the channel is instantiated; no dependencies.
interface itpc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/ipv4_tunnel_packet_checker_core.sv]
// Top level of the IPv4 tunnel packet checker: per-packet state, the
// final-byte verdict logic and the result register.
// Depends on itpc_pkg and itpc_stream_if.
//
// Usage:
//   req_channel carries one packet byte per beat (data_byte, last_byte,
//   check_dst); check_dst is sampled on the first byte of a packet.
//   rsp_channel carries one result beat (verdict, packet_length) for each
//   beat that has last_byte set; other beats give no result.
//   The csr_ port writes assignment_present (0), max_packet_length (1) and
//   the assigned host address (2) at any edge with csr_write_enable high.
// Latency and throughput:
//   One byte is taken every cycle. The result of a final byte is shown in
//   the cycle after that byte is accepted. The rate is set by the single
//   result register: a new byte enters whenever that register is empty or
//   is being emptied in the same cycle.
// Reset:
//   Synchronous reset clears the packet state, empties the result register
//   and loads the registers with 0, 1500 and 0.
// Stall:
//   While a result waits and rsp_channel.ready is low, req_channel.ready is
//   low; the held result does not change.
module ipv4_tunnel_packet_checker_core
   import itpc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   itpc_stream_if.sink                req_channel,
   itpc_stream_if.source              rsp_channel,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // Configuration registers
   logic        assignment_present_ff;
   logic [15:0] max_packet_length_ff;
   logic [31:0] host_address_ff;

   // Per-packet state
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [7:0]             first_header_byte_ff, first_header_byte_in;
   logic [15:0]            declared_total_length_ff, declared_total_length_in;
   logic                   address_matches_ff, address_matches_in;
   logic                   direction_latch_ff, direction_latch_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   req_payload_type        beat;
   logic                   accept;
   logic [COUNT_WIDTH-1:0] pos;
   logic [COUNT_WIDTH-1:0] len;
   logic                   first_pos;
   logic                   direction;
   logic [14:0]            addr_word;
   logic                   in_addr_word;
   logic [7:0]             want_byte;
   logic [7:0]             header_byte;
   logic [15:0]            length_field;
   logic                   address_ok;
   logic [3:0]             version;
   logic [5:0]             header_len;
   verdict_type            verdict;

   assign beat   = req_channel.payload;
   assign accept = req_channel.valid && req_channel.ready;

   // Take a byte when the result register is empty or being drained
   assign req_channel.ready   = !rsp_valid_ff || rsp_channel.ready;
   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_payload_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         assignment_present_ff <= 1'b0;
         max_packet_length_ff  <= MTU_RESET;
         host_address_ff       <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ASSIGNMENT_PRESENT: assignment_present_ff <= csr_write_data[0];
            CSR_MAX_PACKET_LENGTH:  max_packet_length_ff  <= csr_write_data[15:0];
            CSR_HOST_ADDRESS:       host_address_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Capture header fields and check the address byte by byte
   always_comb begin
      pos       = byte_count_ff;
      first_pos = (pos == POS_VERSION);

      header_byte  = first_pos ? beat.data_byte : first_header_byte_ff;
      direction    = first_pos ? beat.check_dst : direction_latch_ff;
      length_field = declared_total_length_ff;
      if (pos == POS_TOTAL_HI) begin
         length_field = {beat.data_byte, declared_total_length_ff[7:0]};
      end else if (pos == POS_TOTAL_LO) begin
         length_field = {declared_total_length_ff[15:8], beat.data_byte};
      end

      // Address word sits at bytes 16..19 when check_dst is set, 12..15 otherwise
      addr_word    = direction ? DST_ADDR_WORD : SRC_ADDR_WORD;
      in_addr_word = (pos[COUNT_WIDTH-1:2] == addr_word);
      unique case (pos[1:0])
         2'd0:    want_byte = host_address_ff[31:24];
         2'd1:    want_byte = host_address_ff[23:16];
         2'd2:    want_byte = host_address_ff[15:8];
         default: want_byte = host_address_ff[7:0];
      endcase
      address_ok = (first_pos ? 1'b1 : address_matches_ff)
                   && !(in_addr_word && (want_byte != beat.data_byte));

      // Saturate the byte count
      len = (byte_count_ff == COUNT_LIMIT) ? byte_count_ff
                                           : byte_count_ff + 1'b1;
   end

   // Decide the verdict in priority order: size, header, address
   always_comb begin
      version    = header_byte[7:4];
      header_len = {header_byte[3:0] & NIBBLE_MASK, 2'b00};
      priority if (!assignment_present_ff || (len < MIN_PACKET_LEN)
                   || (len > {1'b0, max_packet_length_ff})) begin
         verdict = VERDICT_SIZE;
      end else if ((version != IPV4_VERSION) || (header_len < MIN_HEADER_LEN)
                   || ({11'd0, header_len} > len)
                   || ({1'b0, length_field} != len)) begin
         verdict = VERDICT_HEADER;
      end else if (!address_ok) begin
         verdict = VERDICT_ADDRESS;
      end else begin
         verdict = VERDICT_ACCEPT;
      end
   end

   // Advance packet state; clear it after the final byte
   always_comb begin
      byte_count_in            = byte_count_ff;
      first_header_byte_in     = first_header_byte_ff;
      declared_total_length_in = declared_total_length_ff;
      address_matches_in       = address_matches_ff;
      direction_latch_in       = direction_latch_ff;
      if (accept) begin
         if (beat.last_byte) begin
            byte_count_in            = '0;
            first_header_byte_in     = '0;
            declared_total_length_in = '0;
            address_matches_in       = 1'b1;
            direction_latch_in       = 1'b0;
         end else begin
            byte_count_in            = len;
            first_header_byte_in     = header_byte;
            declared_total_length_in = length_field;
            address_matches_in       = address_ok;
            direction_latch_in       = direction;
         end
      end
   end

   // Load the result register on a final byte, drop it when taken
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_channel.ready;
      rsp_payload_in = rsp_payload_ff;
      if (accept && beat.last_byte) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.verdict       = verdict;
         rsp_payload_in.packet_length = len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff            <= '0;
         first_header_byte_ff     <= '0;
         declared_total_length_ff <= '0;
         address_matches_ff       <= 1'b1;
         direction_latch_ff       <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         byte_count_ff            <= byte_count_in;
         first_header_byte_ff     <= first_header_byte_in;
         declared_total_length_ff <= declared_total_length_in;
         address_matches_ff       <= address_matches_in;
         direction_latch_ff       <= direction_latch_in;
         rsp_valid_ff             <= rsp_valid_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule
